// ===== rtl/core/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// sba_pkg
// Command and status codes and field widths for the stack bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

    // field widths
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned LOC_W   = 5;
    localparam int unsigned OFF_W   = 15;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned DEPTH_W = 5;

    // stream widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 24;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] status_t;

    // command codes
    localparam cmd_t CMD_RESET   = 3'd0;
    localparam cmd_t CMD_ALLOC   = 3'd1;
    localparam cmd_t CMD_POP     = 3'd2;
    localparam cmd_t CMD_GET_LOC = 3'd3;
    localparam cmd_t CMD_SET_LOC = 3'd4;
    localparam cmd_t CMD_FREE    = 3'd5;

    // status codes
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_TOO_MANY = 3'd1;
    localparam status_t ST_OOM      = 3'd2;
    localparam status_t ST_NOT_TOP  = 3'd3;
    localparam status_t ST_LOC_REJ  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/stack_bump_allocator_core.sv =====
// ----------------------------------------------------------------------------
// stack_bump_allocator_core
// LIFO bump allocator over a fixed byte heap, offsets kept in a small
// synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                        | contents
//  --------+-----+------------------------------+------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata    | command in tuser, arguments in
//          |     | s_tuser                      | tdata
//  m_      | out | m_tvalid m_tready m_tdata    | status, block offset, depth
//
//  Each transaction has two steps: a read of the offset memory at the stack
//  top, then execute and write back. The memory read port sets this.
//  The next command is taken while a result still waits on the m_ side.
//  aresetn clears the depth and the per-entry valid bits together; an
//  entry never written reads as zero. No clearing pass.
//  A stalled m_ side holds the execute step until the output register frees.
//
`default_nettype none

module stack_bump_allocator_core #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned HEAP_BYTES  = 16384,
    parameter int unsigned ALIGN_BYTES = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [15:0] alloc_size, [20:16] new_location, [35:21] block_offset
    input  wire logic [sba_pkg::S_DATA_W-1:0]   s_tdata,
    // [2:0] cmd
    input  wire logic [sba_pkg::CMD_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [2:0] status, [17:3] alloc_offset, [22:18] depth
    output logic [sba_pkg::M_DATA_W-1:0]        m_tdata
);

    import sba_pkg::*;

    localparam int unsigned ENTRIES = MAX_ENTRIES + 1;
    localparam int unsigned AW      = $clog2(ENTRIES);
    localparam int unsigned OW      = $clog2(HEAP_BYTES);
    // size plus alignment slack stays below 2**XW
    localparam int unsigned XW      = 17;
    localparam int unsigned LW      = $clog2(ALIGN_BYTES);
    localparam int unsigned SH      = XW + LW;
    localparam int unsigned RW      = SH + 1;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
    localparam int unsigned EW      = ((OW > XW) ? OW : XW) + 1;
    localparam int unsigned CW      = (OW > OFF_W) ? OW : OFF_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic               state_reg, state_next;
    logic [AW-1:0]      depth_reg, depth_next;
    logic [ENTRIES-1:0] vld_reg;

    logic [OW-1:0]      mem [ENTRIES];
    logic [OW-1:0]      rd_data_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      rd_addr;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [OW-1:0]      wr_data;

    cmd_t               cmd_reg;
    logic [XW-1:0]      q_reg;
    logic [LOC_W-1:0]   loc_reg;
    logic [OFF_W-1:0]   blk_reg;

    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic               s_fire;
    logic               exec_go;
    logic [SIZE_W-1:0]  s_size;
    logic [XW-1:0]      x_sum;
    logic [XW+RW-1:0]   prod;
    logic [2*XW-1:0]    rnd_full;
    logic [XW-1:0]      rounded;
    logic [OW-1:0]      top;
    logic [EW-1:0]      end_off;
    status_t            status_next;
    logic [OFF_W-1:0]   off_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ceil(size / align) by reciprocal multiplication, exact for x < 2**XW
    assign s_size = s_tdata[SIZE_W-1:0];
    assign x_sum  = XW'(s_size) + XW'(ALIGN_BYTES - 1);
    assign prod   = {{RW{1'b0}}, x_sum} * {{XW{1'b0}}, RECIP};

    // free looks at the entry under the top, everything else at the top
    always_comb begin
        if (s_tuser == CMD_FREE && depth_reg != '0) begin
            rd_addr = depth_reg - AW'(1);
        end else begin
            rd_addr = depth_reg;
        end
    end

    assign rnd_full = {{XW{1'b0}}, q_reg} * {{XW{1'b0}}, XW'(ALIGN_BYTES)};
    assign rounded  = rnd_full[XW-1:0];
    assign top      = rd_vld_reg ? rd_data_reg : '0;
    assign end_off  = EW'(top) + EW'(rounded);

    always_comb begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        status_next = ST_OK;
        off_next    = '0;
        wr_en       = 1'b0;
        wr_addr     = depth_reg + AW'(1);
        wr_data     = end_off[OW-1:0];
        if (s_fire) begin
            state_next = ST_EXEC;
        end
        if (exec_go) begin
            state_next = ST_IDLE;
            case (cmd_reg)
                CMD_RESET: begin
                    depth_next = '0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = '0;
                end
                CMD_ALLOC: begin
                    if (32'(depth_reg) >= MAX_ENTRIES) begin
                        status_next = ST_TOO_MANY;
                    end else if (end_off >= EW'(HEAP_BYTES)) begin
                        status_next = ST_OOM;
                    end else begin
                        wr_en      = 1'b1;
                        depth_next = depth_reg + AW'(1);
                        off_next   = OFF_W'(top);
                    end
                end
                CMD_POP: begin
                    if (depth_reg != '0) begin
                        depth_next = depth_reg - AW'(1);
                    end
                end
                CMD_GET_LOC: begin
                end
                CMD_SET_LOC: begin
                    if (32'(loc_reg) < MAX_ENTRIES) begin
                        depth_next = AW'(loc_reg);
                    end else begin
                        status_next = ST_LOC_REJ;
                    end
                end
                CMD_FREE: begin
                    if (depth_reg != '0 && CW'(top) == CW'(blk_reg)) begin
                        depth_next = depth_reg - AW'(1);
                    end else begin
                        status_next = ST_NOT_TOP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // offset memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (s_fire) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_tuser;
            q_reg   <= prod[SH +: XW];
            loc_reg <= s_tdata[SIZE_W +: LOC_W];
            blk_reg <= s_tdata[SIZE_W+LOC_W +: OFF_W];
        end
        if (exec_go) begin
            m_tdata_reg <= {M_DATA_W'(0)}
                         | M_DATA_W'({DEPTH_W'(depth_next), off_next, status_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (s_fire) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(depth_reg) <= MAX_ENTRIES)
        else $error("stack depth above limit");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not reach execute");

    a_write_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> exec_go)
        else $error("memory write outside execute");

    a_alloc_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && cmd_reg == CMD_ALLOC && status_next == ST_OK)
        |=> depth_reg == $past(depth_reg) + AW'(1))
        else $error("successful alloc did not push");

    a_offset_only_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && cmd_reg != CMD_ALLOC) |-> off_next == '0)
        else $error("block offset on a non-alloc command");

endmodule

`default_nettype wire

// ===== sim/tb_stack_bump_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_stack_bump_allocator_core
// Self-checking testbench for the stack bump allocator. Commands go in on the
// s_ stream and results come out on the m_ stream. A local allocator model
// predicts every result in order of acceptance. A checker compares each result
// transaction field by field with the oldest prediction. Both sides insert
// random idle cycles, and one phase holds the receiver off long enough to
// stall the command stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_stack_bump_allocator_core;

    import sba_pkg::*;

    localparam int unsigned MAX_ENTRIES  = 16;
    localparam int unsigned HEAP_BYTES   = 16384;
    localparam int unsigned ALIGN_BYTES  = 8;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // codes the block treats as no-ops
    localparam cmd_t CMD_SPARE_6 = 3'd6;
    localparam cmd_t CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        status_t              status;
        logic [OFF_W-1:0]     alloc_offset;
        logic [DEPTH_W-1:0]   depth;
    } alloc_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // [15:0] alloc_size, [20:16] new_location, [35:21] block_offset
    logic [S_DATA_W-1:0]     s_tdata;
    // [2:0] cmd
    logic [CMD_W-1:0]        s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    // [2:0] status, [17:3] alloc_offset, [22:18] depth
    logic [M_DATA_W-1:0]     m_tdata;

    // allocator model state
    logic [OFF_W-1:0]        model_offsets [0:MAX_ENTRIES];
    int unsigned             model_depth;

    alloc_result_t           expected_results [$];
    int unsigned             error_count;
    int unsigned             quiet_cycles;
    bit                      tx_idle;
    bit                      rx_idle;
    bit                      hold_request;

    stack_bump_allocator_core #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .HEAP_BYTES  (HEAP_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic alloc_result_t predict_alloc(cmd_t cmd, logic [SIZE_W-1:0] size,
                                                    logic [LOC_W-1:0] loc,
                                                    logic [OFF_W-1:0] blk);
        alloc_result_t res;
        int unsigned   start;
        int unsigned   rounded;
        int unsigned   fin;
        res.status       = ST_OK;
        res.alloc_offset = '0;
        case (cmd)
            CMD_RESET: begin
                model_depth      = 0;
                model_offsets[0] = '0;
            end
            CMD_ALLOC: begin
                if (model_depth >= MAX_ENTRIES) begin
                    res.status = ST_TOO_MANY;
                end else begin
                    start   = 32'(model_offsets[model_depth]);
                    rounded = ((32'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                    fin     = start + rounded;
                    if (fin >= HEAP_BYTES) begin
                        res.status = ST_OOM;
                    end else begin
                        model_offsets[model_depth + 1] = fin[OFF_W-1:0];
                        model_depth                    = model_depth + 1;
                        res.alloc_offset               = start[OFF_W-1:0];
                    end
                end
            end
            CMD_POP: begin
                if (model_depth > 0) model_depth = model_depth - 1;
            end
            CMD_GET_LOC: begin
            end
            CMD_SET_LOC: begin
                if (32'(loc) < MAX_ENTRIES) model_depth = 32'(loc);
                else res.status = ST_LOC_REJ;
            end
            CMD_FREE: begin
                if (model_depth > 0 && model_offsets[model_depth - 1] == blk) begin
                    model_depth = model_depth - 1;
                end else begin
                    res.status = ST_NOT_TOP;
                end
            end
            default: begin
            end
        endcase
        res.depth = model_depth[DEPTH_W-1:0];
        return res;
    endfunction

    // offer one command, predict its result once the transaction is taken
    task automatic issue_command(cmd_t cmd, logic [SIZE_W-1:0] size,
                                 logic [LOC_W-1:0] loc, logic [OFF_W-1:0] blk);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, blk, loc, size};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_alloc(cmd, size, loc, blk));
    endtask

    function automatic logic [OFF_W-1:0] top_block_start();
        if (model_depth == 0) return '0;
        return model_offsets[model_depth - 1];
    endfunction

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        issue_command(CMD_GET_LOC, 16'hffff, 5'd31, 15'h7fff);
        issue_command(CMD_POP,     16'h0000, 5'd0,  15'h0000);
        // free with nothing allocated
        issue_command(CMD_FREE,    16'h0000, 5'd0,  15'h0000);
        issue_command(CMD_ALLOC,   16'h0000, 5'd0,  15'h0000);
        issue_command(CMD_ALLOC,   16'h0001, 5'd0,  15'h0000);
        issue_command(CMD_FREE,    16'h0000, 5'd0,  15'h0004);
        issue_command(CMD_FREE,    16'h0000, 5'd0,  15'h0000);
        issue_command(CMD_ALLOC,   16'd16368, 5'd0, 15'h0000);
        // end offset lands exactly on the heap size
        issue_command(CMD_ALLOC,   16'd16,    5'd0, 15'h0000);
        issue_command(CMD_ALLOC,   16'd8,     5'd0, 15'h0000);
        issue_command(CMD_ALLOC,   16'hffff,  5'd0, 15'h0000);
        issue_command(CMD_SET_LOC, 16'h0000, 5'd31, 15'h0000);
        issue_command(CMD_SET_LOC, 16'h0000, 5'd16, 15'h0000);
        // jump up over entries that were never written
        issue_command(CMD_SET_LOC, 16'h0000, 5'd15, 15'h0000);
        issue_command(CMD_ALLOC,   16'd9,     5'd0, 15'h0000);
        issue_command(CMD_ALLOC,   16'd1,     5'd0, 15'h0000);
        issue_command(CMD_GET_LOC, 16'h0000, 5'd0,  15'h0000);
        issue_command(CMD_SPARE_6, 16'hffff, 5'd31, 15'h7fff);
        issue_command(CMD_SPARE_7, 16'h0000, 5'd0,  15'h0000);
        issue_command(CMD_FREE,    16'h0000, 5'd0,  top_block_start());
        issue_command(CMD_SET_LOC, 16'h0000, 5'd2,  15'h0000);
        issue_command(CMD_FREE,    16'h0000, 5'd0,  15'h7fff);
        issue_command(CMD_RESET,   16'hffff, 5'd31, 15'h7fff);
        issue_command(CMD_SET_LOC, 16'h0000, 5'd0,  15'h0000);
        issue_command(CMD_ALLOC,   16'd16375, 5'd0, 15'h0000);
    endtask

    // mostly alloc/free stacks, with pops, jumps, resets and raw noise mixed in
    task automatic test_random_mix(int unsigned count);
        int unsigned      pick;
        cmd_t             cmd;
        logic [SIZE_W-1:0] size;
        logic [LOC_W-1:0]  loc;
        logic [OFF_W-1:0]  blk;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            size = SIZE_W'($urandom());
            loc  = LOC_W'($urandom());
            blk  = OFF_W'($urandom());
            if (pick < 40) begin
                cmd = CMD_ALLOC;
                if ($urandom_range(0, 99) < 85) size = SIZE_W'($urandom_range(0, 1500));
            end else if (pick < 58) begin
                cmd = CMD_FREE;
                if ($urandom_range(0, 99) < 75) blk = top_block_start();
            end else if (pick < 67) begin
                cmd = CMD_POP;
            end else if (pick < 76) begin
                cmd = CMD_SET_LOC;
                if ($urandom_range(0, 99) < 70) loc = LOC_W'($urandom_range(0, MAX_ENTRIES));
            end else if (pick < 84) begin
                cmd = CMD_GET_LOC;
            end else if (pick < 89) begin
                cmd = CMD_RESET;
            end else begin
                cmd = cmd_t'($urandom_range(0, 7));
            end
            issue_command(cmd, size, loc, blk);
        end
    endtask

    task automatic test_backpressure();
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 1'b1;
        test_random_mix(80);
    endtask

    // result side: per-transaction stall, plus one long hold on request
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_results
        alloc_result_t exp_res;
        alloc_result_t got_res;
        if (aresetn && m_tvalid && m_tready) begin
            got_res.status       = m_tdata[2:0];
            got_res.alloc_offset = m_tdata[17:3];
            got_res.depth        = m_tdata[22:18];
            if (expected_results.size() == 0) begin
                $error("result transaction with no command outstanding: %h", m_tdata);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (got_res.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, got_res.status);
                    error_count++;
                end
                if (got_res.alloc_offset !== exp_res.alloc_offset) begin
                    $error("alloc_offset: expected %0d, got %0d",
                           exp_res.alloc_offset, got_res.alloc_offset);
                    error_count++;
                end
                if (got_res.depth !== exp_res.depth) begin
                    $error("depth: expected %0d, got %0d", exp_res.depth, got_res.depth);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        error_count  = 0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 1'b0;
        model_depth  = 0;
        for (int i = 0; i <= MAX_ENTRIES; i++) model_offsets[i] = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        tx_idle = 1'b1; rx_idle = 1'b1;
        test_random_mix(260);
        tx_idle = 1'b0; rx_idle = 1'b0;
        test_random_mix(260);
        tx_idle = 1'b1; rx_idle = 1'b0;
        test_random_mix(240);
        tx_idle = 1'b0; rx_idle = 1'b1;
        test_random_mix(240);
        test_backpressure();
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
